@@ rtl/core/dqe_pkg.sv @@
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types and constants for the DNS question-name encoder.
// ----------------------------------------------------------------------------
package dqe_pkg;

    localparam int LABEL_DEPTH = 32;
    localparam int CNT_W       = $clog2(LABEL_DEPTH + 1);

    localparam logic [CNT_W-1:0] LABEL_FULL = CNT_W'(LABEL_DEPTH);

    localparam logic [7:0] CHAR_TERM  = 8'h00;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [15:0] QTYPE_A   = 16'h0001;
    localparam logic [15:0] QCLASS_IN = 16'h0001;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_DATA,
        S_ROOT,
        S_TYPE_HI,
        S_TYPE_LO,
        S_CLASS_HI,
        S_CLASS_LO
    } t_state;

    // control broadcast along the label chain
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] char_byte;
    } t_chain_ctrl;

endpackage

@@ rtl/core/dqe_label_cell.sv @@
// ----------------------------------------------------------------------------
// dqe_label_cell
// One character slot of the label chain: fills in order, shifts toward head.
// ----------------------------------------------------------------------------
module dqe_label_cell
    import dqe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_ctrl i_ctrl,
    input  logic        i_prev_occ,
    input  logic [7:0]  i_next_data,
    input  logic        i_next_occ,
    output logic [7:0]  o_data,
    output logic        o_occ
);

    logic [7:0] r_data;
    logic       r_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctrl.pop) begin
            r_occ <= i_next_occ;
        end else if (i_ctrl.push && !r_occ && i_prev_occ) begin
            r_occ <= 1'b1;
        end
    end

    // first free slot takes the new character
    always_ff @(posedge i_clk) begin
        if (i_ctrl.pop) begin
            r_data <= i_next_data;
        end else if (i_ctrl.push && !r_occ && i_prev_occ) begin
            r_data <= i_ctrl.char_byte;
        end
    end

    assign o_data = r_data;
    assign o_occ  = r_occ;

endmodule

@@ rtl/core/dqe_label_chain.sv @@
// ----------------------------------------------------------------------------
// dqe_label_chain
// Row of label cells; oldest character always sits in the head cell.
// ----------------------------------------------------------------------------
module dqe_label_chain
    import dqe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_ctrl i_ctrl,
    output logic [7:0]  o_head_data,
    output logic        o_head_occ
);

    logic [7:0] w_data [LABEL_DEPTH+1];
    logic       w_occ  [LABEL_DEPTH+1];

    // slot past the tail reads as empty
    assign w_data[LABEL_DEPTH] = 8'h00;
    assign w_occ[LABEL_DEPTH]  = 1'b0;

    for (genvar g = 0; g < LABEL_DEPTH; g++) begin : g_cell
        logic w_prev_occ;
        if (g == 0) begin : g_head
            assign w_prev_occ = 1'b1;
        end else begin : g_body
            assign w_prev_occ = w_occ[g-1];
        end

        dqe_label_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_prev_occ  (w_prev_occ),
            .i_next_data (w_data[g+1]),
            .i_next_occ  (w_occ[g+1]),
            .o_data      (w_data[g]),
            .o_occ       (w_occ[g])
        );
    end

    assign o_head_data = w_data[0];
    assign o_head_occ  = w_occ[0];

endmodule

@@ rtl/core/dns_qname_encoder_core.sv @@
// ----------------------------------------------------------------------------
// dns_qname_encoder_core
// Encodes a host name, one character per item, into DNS question-field bytes.
// ----------------------------------------------------------------------------
// Input stream: i_s_tdata carries one name character; 0x00 ends the name.
// Output stream: o_m_tdata carries one encoded byte; o_m_tlast marks the low
// byte of the class; o_m_tuser[0] flags that some label of the name overflowed.
// An ordinary character is accepted and shifted into the label chain. A dot
// is accepted, then the length byte and the n buffered characters are
// emitted; the characters drain from the head cell of the chain one per
// cycle while the output is not stalled. The terminator of a non-empty name
// adds the pending label, then five trailer bytes (root, type A, class IN),
// one per cycle unless the output stalls. Input is accepted only while no
// emission is in progress; the output byte is registered.
// A stall on the output holds the output register and freezes emission; the
// input side waits until the emission finishes. Synchronous reset empties
// the chain and clears all name state; buffered bytes are not cleared.
// ----------------------------------------------------------------------------
module dns_qname_encoder_core
    import dqe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,
    output logic [0:0] o_m_tuser    // [0] label_too_long
);

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic r_stopped, n_stopped;
    logic r_any, n_any;
    logic r_ovf, n_ovf;
    logic r_term, n_term;

    logic       r_m_tvalid;
    logic [7:0] r_m_tdata;
    logic       r_m_tlast;
    logic       r_m_tuser;

    logic        w_accept;
    logic        w_slot;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic        w_last;
    t_chain_ctrl w_ctrl;
    logic [7:0]  w_head_data;
    logic        w_head_occ;
    logic        w_is_term;
    logic        w_is_dot;
    logic        w_is_slash;

    assign w_slot     = !r_m_tvalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_is_term  = (i_s_tdata == CHAR_TERM);
    assign w_is_dot   = (i_s_tdata == CHAR_DOT);
    assign w_is_slash = (i_s_tdata == CHAR_SLASH);

    dqe_label_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_head_data (w_head_data),
        .o_head_occ  (w_head_occ)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_is_term) begin
                        if (r_any) begin
                            n_state = (r_count != '0) ? S_LEN : S_ROOT;
                        end
                    end else if (!r_stopped && w_is_dot) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (w_slot) begin
                    if (r_count != '0) begin
                        n_state = S_DATA;
                    end else begin
                        n_state = r_term ? S_ROOT : S_IDLE;
                    end
                end
            end
            S_DATA: begin
                if (w_slot && r_count == CNT_W'(1)) begin
                    n_state = r_term ? S_ROOT : S_IDLE;
                end
            end
            S_ROOT:     if (w_slot) n_state = S_TYPE_HI;
            S_TYPE_HI:  if (w_slot) n_state = S_TYPE_LO;
            S_TYPE_LO:  if (w_slot) n_state = S_CLASS_HI;
            S_CLASS_HI: if (w_slot) n_state = S_CLASS_LO;
            S_CLASS_LO: if (w_slot) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_emit = 1'b0;
        w_byte = 8'h00;
        w_last = 1'b0;
        w_ctrl.push      = 1'b0;
        w_ctrl.pop       = 1'b0;
        w_ctrl.char_byte = i_s_tdata;
        unique case (r_state)
            S_IDLE: begin
                w_ctrl.push = w_accept && !w_is_term && !r_stopped && !w_is_dot
                              && !w_is_slash && (r_count < LABEL_FULL);
            end
            S_LEN: begin
                w_emit = w_slot;
                w_byte = 8'(r_count);
            end
            S_DATA: begin
                w_emit     = w_slot;
                w_byte     = w_head_data;
                w_ctrl.pop = w_slot;
            end
            S_ROOT: begin
                w_emit = w_slot;
            end
            S_TYPE_HI: begin
                w_emit = w_slot;
                w_byte = QTYPE_A[15:8];
            end
            S_TYPE_LO: begin
                w_emit = w_slot;
                w_byte = QTYPE_A[7:0];
            end
            S_CLASS_HI: begin
                w_emit = w_slot;
                w_byte = QCLASS_IN[15:8];
            end
            S_CLASS_LO: begin
                w_emit = w_slot;
                w_byte = QCLASS_IN[7:0];
                w_last = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // name state
    always_comb begin
        n_count   = r_count;
        n_stopped = r_stopped;
        n_any     = r_any;
        n_ovf     = r_ovf;
        n_term    = r_term;
        if (w_accept) begin
            if (w_is_term) begin
                n_stopped = 1'b0;
                n_any     = 1'b0;
                n_term    = 1'b1;
                if (!r_any) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end else begin
                n_any = 1'b1;
                if (!r_stopped) begin
                    priority if (w_is_slash) begin
                        n_stopped = 1'b1;
                    end else if (w_is_dot) begin
                        n_term = 1'b0;
                    end else if (r_count < LABEL_FULL) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
        end
        if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        // flag lives until the last byte of the name has gone out
        if (w_emit && w_last) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_stopped  <= 1'b0;
            r_any      <= 1'b0;
            r_ovf      <= 1'b0;
            r_term     <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_stopped <= n_stopped;
            r_any     <= n_any;
            r_ovf     <= n_ovf;
            r_term    <= n_term;
            if (w_emit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_m_tdata <= w_byte;
            r_m_tlast <= w_last;
            r_m_tuser <= r_ovf;
        end
    end

    assign o_m_tvalid   = r_m_tvalid;
    assign o_m_tdata    = r_m_tdata;
    assign o_m_tlast    = r_m_tlast;
    assign o_m_tuser[0] = r_m_tuser;

`ifndef SYNTHESIS
    a_data_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_count != '0))
        else $error("label drain with empty count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LABEL_FULL)
        else $error("label count beyond depth");

    a_chain_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_head_occ == (r_count != '0))
        else $error("chain occupancy disagrees with label count");

    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == QCLASS_IN[7:0]))
        else $error("last byte is not the class low byte");

    a_last_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> !r_ovf)
        else $error("overflow flag survived end of name");
`endif

endmodule

@@ tb/dns_qname_encoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_qname_encoder_core_test
// Self-checking bench for the DNS question-name encoder.
// ----------------------------------------------------------------------------
// Feeds host-name characters on the input stream and predicts the wire-form
// question bytes (length-prefixed labels, root, type A, class IN) together
// with the last marker and the overflow flag. Every output item is compared
// with the oldest predicted byte. A short directed table, then a too-long
// label under one long output stall, then random names in three idle mixes.
// ----------------------------------------------------------------------------
module dns_qname_encoder_core_test;
    import dqe_pkg::*;

    localparam int         STALL_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         PHASE_ITEMS = 35;
    localparam int         IDX_W       = $clog2(LABEL_DEPTH);
    localparam logic [7:0] N_PREDICTED = 8'hFF;  // row count left to predictor

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       too_long;
    } t_wire_byte;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] n_bytes;
    } t_dir_row;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = 8'h00;
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;   // [7:0] out_byte
    logic       o_m_tlast;
    logic [0:0] o_m_tuser;   // [0] label_too_long

    dns_qname_encoder_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [7:0]       lbl_buf [LABEL_DEPTH];
    logic [CNT_W-1:0] lbl_cnt    = '0;
    logic             slash_seen = 1'b0;
    logic             name_open  = 1'b0;
    logic             label_ovf  = 1'b0;
    t_wire_byte       wire_q [$];

    int errors        = 0;
    int items_sent    = 0;
    int names_done    = 0;
    int bytes_checked = 0;
    int flagged_bytes = 0;
    int quiet         = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_reqs     = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    t_wire_byte got_b;
    t_wire_byte exp_b;

    t_dir_row dir_tab [0:22] = '{
        '{CHAR_TERM,  8'd0},        // empty name right after reset
        '{CHAR_DOT,   8'd1},        // empty label: zero length
        '{CHAR_TERM,  8'd5},        // trailing dot: trailer only
        '{CHAR_SLASH, 8'd0},        // slash first
        '{8'hFF,      8'd0},        // ignored after slash
        '{CHAR_TERM,  8'd5},
        '{8'h01,      8'd0},
        '{8'hFF,      8'd0},
        '{CHAR_DOT,   8'd3},
        '{8'h7F,      8'd0},
        '{CHAR_TERM,  8'd7},
        '{8'h80,      8'd0},
        '{CHAR_SLASH, 8'd0},
        '{CHAR_DOT,   8'd0},        // dot after slash does nothing
        '{8'h55,      8'd0},
        '{CHAR_TERM,  8'd7},
        '{8'hAA,      8'd0},
        '{CHAR_DOT,   8'd2},
        '{CHAR_DOT,   8'd1},
        '{CHAR_TERM,  8'd5},
        '{8'h2D,      N_PREDICTED},
        '{8'h30,      N_PREDICTED},
        '{CHAR_TERM,  N_PREDICTED}
    };

    task automatic report(input string msg);
        errors++;
        if (errors <= 10) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic void emit_byte(input logic [7:0] b, input logic last);
        wire_q.push_back('{data: b, last: last, too_long: label_ovf});
    endfunction

    function automatic void emit_label();
        emit_byte(8'(lbl_cnt), 1'b0);
        for (int k = 0; k < int'(lbl_cnt); k++) emit_byte(lbl_buf[k], 1'b0);
        lbl_cnt = '0;
    endfunction

    // returns the number of question bytes the character produces
    function automatic int encode_char(input logic [7:0] c);
        int n0;
        n0 = wire_q.size();
        if (c == CHAR_TERM) begin
            if (name_open) begin
                if (lbl_cnt != 0) emit_label();
                emit_byte(8'h00, 1'b0);
                emit_byte(QTYPE_A[15:8], 1'b0);
                emit_byte(QTYPE_A[7:0], 1'b0);
                emit_byte(QCLASS_IN[15:8], 1'b0);
                emit_byte(QCLASS_IN[7:0], 1'b1);
                names_done++;
            end
            lbl_cnt    = '0;
            slash_seen = 1'b0;
            name_open  = 1'b0;
            label_ovf  = 1'b0;
        end else begin
            name_open = 1'b1;
            if (!slash_seen) begin
                if (c == CHAR_SLASH) begin
                    slash_seen = 1'b1;
                end else if (c == CHAR_DOT) begin
                    emit_label();
                end else if (lbl_cnt < LABEL_FULL) begin
                    lbl_buf[lbl_cnt[IDX_W-1:0]] = c;
                    lbl_cnt = lbl_cnt + CNT_W'(1);
                end else begin
                    label_ovf = 1'b1;
                end
            end
        end
        return wire_q.size() - n0;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CHAR_DOT || c == CHAR_SLASH);
        return c;
    endfunction

    // n_typed < 0: count is taken from the predictor alone
    task automatic send_char(input logic [7:0] c, input int n_typed);
        int got;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tdata  <= c;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        got = encode_char(c);
        items_sent++;
        if (n_typed >= 0 && got != n_typed)
            report($sformatf("char %02h: predictor gives %0d bytes, table says %0d",
                             c, got, n_typed));
    endtask

    // output ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_taken != hold_reqs) begin
            hold_taken = hold_reqs;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // output check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
            if (o_m_tvalid && i_m_tready) begin
                got_b = '{data: o_m_tdata, last: o_m_tlast, too_long: o_m_tuser[0]};
                if (wire_q.size() == 0) begin
                    report($sformatf("unexpected item data=%02h last=%0b flag=%0b",
                                     got_b.data, got_b.last, got_b.too_long));
                end else begin
                    exp_b = wire_q.pop_front();
                    if (got_b.data !== exp_b.data)
                        report($sformatf("data exp %02h got %02h", exp_b.data, got_b.data));
                    if (got_b.last !== exp_b.last)
                        report($sformatf("last exp %0b got %0b", exp_b.last, got_b.last));
                    if (got_b.too_long !== exp_b.too_long)
                        report($sformatf("too_long exp %0b got %0b",
                                         exp_b.too_long, got_b.too_long));
                    bytes_checked++;
                    if (exp_b.too_long) flagged_bytes++;
                end
            end
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("dns_qname_encoder_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        int start;
        int labels;
        int len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 25;
        rx_idle_pct = 79;
        foreach (dir_tab[k])
            send_char(dir_tab[k].ch, (dir_tab[k].n_bytes == N_PREDICTED) ?
                      -1 : int'(dir_tab[k].n_bytes));

        // overflowing label while the output is held off: input must back up
        hold_reqs++;
        repeat (40) send_char(plain_char(), -1);
        send_char(CHAR_DOT, LABEL_DEPTH + 1);
        repeat (3) send_char(plain_char(), -1);
        send_char(CHAR_TERM, -1);
        i_s_tvalid <= 1'b0;
        while (wire_q.size() != 0) @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            unique case (phase)
                0: begin tx_idle_pct = 25; rx_idle_pct = 79; end
                1: begin tx_idle_pct = 79; rx_idle_pct = 25; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    // raw noise, terminators included
                    repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), -1);
                end else begin
                    labels = $urandom_range(1, 4);
                    for (int l = 0; l < labels; l++) begin
                        len = ($urandom_range(7) == 0) ? $urandom_range(30, 40)
                                                       : $urandom_range(0, 8);
                        repeat (len) send_char(plain_char(), -1);
                        if (l < labels - 1 || $urandom_range(3) == 0)
                            send_char(CHAR_DOT, -1);
                    end
                    if ($urandom_range(5) == 0) begin
                        send_char(CHAR_SLASH, -1);
                        repeat ($urandom_range(0, 4))
                            send_char(8'($urandom_range(1, 255)), -1);
                    end
                    send_char(CHAR_TERM, -1);
                end
            end
        end
        i_s_tvalid <= 1'b0;

        while (wire_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d characters, %0d names, %0d output items checked (%0d flagged)",
                 items_sent, names_done, bytes_checked, flagged_bytes);
        $display("idle mixes 25/79, 79/25, none; one %0d-cycle output hold; %0d mismatches",
                 HOLD_CYCLES, errors);
        if (errors == 0)
            $display("dns_qname_encoder_core verification clean");
        else
            $display("dns_qname_encoder_core verification failed");
        $finish;
    end

endmodule
